// File: rtl/hkvt_pkg.sv
`timescale 1ns / 1ps

package hkvt_pkg;

   // default geometry
   localparam int BUCKETS_DEF = 1024;
   localparam int WAYS_DEF    = 4;

   // field widths
   localparam int KIND_W  = 2;
   localparam int KEY_W   = 31;
   localparam int VAL_W   = 31;
   localparam int RES_W   = 32;
   localparam int SLOT_W  = 1 + KEY_W + VAL_W;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_PUT    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_GET    = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

   // result on a miss
   localparam logic signed [RES_W-1:0] RES_MISS = '1;

   // one slot of a bucket row
   typedef struct packed {
      logic             valid;
      logic [KEY_W-1:0] key;
      logic [VAL_W-1:0] value;
   } slot_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_READ,
      ST_SCAN,
      ST_WRITE,
      ST_RESP
   } state_type;

endpackage

// File: rtl/hashed_key_value_table.sv
`timescale 1ns / 1ps
// a request goes through the key modulo (a mask when BUCKETS is a power of two, else the
// quotient, remainder and correction steps), the row read, the way scan, the write and the response
// one request at a time, taken only in idle; ways are scanned by the single way comparator
// reset: synchronous; a clearing pass then writes one bucket row per cycle, with req_ready
// low until it ends

module hashed_key_value_table #(
   parameter int BUCKETS = hkvt_pkg::BUCKETS_DEF,
   parameter int WAYS    = hkvt_pkg::WAYS_DEF
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_ready,
   input  logic [hkvt_pkg::KIND_W-1:0]             req_kind,
   input  logic [hkvt_pkg::KEY_W-1:0]              req_key,
   input  logic [hkvt_pkg::VAL_W-1:0]              req_value,
   output logic                                    rsp_valid,
   input  logic                                    rsp_ready,
   output logic                                    rsp_found,
   output logic signed [hkvt_pkg::RES_W-1:0]       rsp_result_value,
   output logic                                    rsp_full_res
);

   // bucket row address and way index widths
   localparam int AW     = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
   localparam int WW     = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int ROW_W  = WAYS * hkvt_pkg::SLOT_W;
   localparam bit POW2   = ((BUCKETS & (BUCKETS - 1)) == 0);

   // reciprocal of BUCKETS, rounded down; the quotient estimate is exact or one short
   localparam int          LOG_B        = (BUCKETS > 1) ? $clog2(BUCKETS) : 0;
   localparam int          RECIP_SH     = hkvt_pkg::KEY_W + LOG_B;
   localparam logic [63:0] RECIP_M64    = (64'd1 << RECIP_SH) / 64'(BUCKETS);
   localparam logic [31:0] RECIP_M      = RECIP_M64[31:0];
   localparam int          RECIP_PROD_W = hkvt_pkg::KEY_W + 32;
   localparam logic [AW:0] BUCKETS_W    = (AW + 1)'(BUCKETS);
   localparam logic [1:0]  MOD_LAST     = 2'd2;

   // sequencer state
   hkvt_pkg::state_type state_ff, state_in;

   // clearing pass row pointer
   logic [AW-1:0] clr_addr_ff, clr_addr_in;

   // latched request
   logic [hkvt_pkg::KIND_W-1:0] kind_ff, kind_in;
   logic [hkvt_pkg::KEY_W-1:0]  key_ff, key_in;
   logic [hkvt_pkg::VAL_W-1:0]  value_ff, value_in;

   // key modulo: quotient estimate, remainder below 2*BUCKETS, one correction step
   logic [1:0]                    mod_cnt_ff, mod_cnt_in;
   logic [hkvt_pkg::KEY_W-1:0]    quot_ff, quot_in;
   logic [AW:0]                   rem_ff, rem_in;
   logic [AW-1:0]                 bucket_ff, bucket_in;
   logic [RECIP_PROD_W-1:0]       recip_prod;
   logic [RECIP_PROD_W-1:0]       recip_shift;
   logic [AW:0]                   quot_times_b;

   // way scan
   logic [WW-1:0] way_ff, way_in;
   logic          found_ff, found_in;
   logic          has_free_ff, has_free_in;
   logic [WW-1:0] hit_ff, hit_in;
   logic [WW-1:0] free_ff, free_in;

   // finished result waiting for the output register
   logic                              res_found_ff, res_found_in;
   logic signed [hkvt_pkg::RES_W-1:0] res_value_ff, res_value_in;
   logic                              res_full_ff, res_full_in;

   // output register
   logic                              rsp_valid_ff, rsp_valid_in;
   logic                              rsp_found_ff, rsp_found_in;
   logic signed [hkvt_pkg::RES_W-1:0] rsp_value_ff, rsp_value_in;
   logic                              rsp_full_ff, rsp_full_in;

   // bucket row memory
   logic             ram_wr_en;
   logic [AW-1:0]    ram_wr_addr;
   logic [ROW_W-1:0] ram_wr_data;
   logic             ram_rd_en;
   logic [ROW_W-1:0] ram_rd_data;

   // shared comparator view of one way
   hkvt_pkg::slot_type scan_slot;
   hkvt_pkg::slot_type hit_slot;
   hkvt_pkg::slot_type new_slot;
   logic               key_match;

   hkvt_ram #(
      .WIDTH (ROW_W),
      .DEPTH (BUCKETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (bucket_ff),
      .rd_data (ram_rd_data)
   );

   // one way at a time goes through the key comparator
   assign scan_slot = hkvt_pkg::slot_type'(ram_rd_data[way_ff * hkvt_pkg::SLOT_W +:
                                                       hkvt_pkg::SLOT_W]);
   assign hit_slot  = hkvt_pkg::slot_type'(ram_rd_data[hit_ff * hkvt_pkg::SLOT_W +:
                                                       hkvt_pkg::SLOT_W]);
   assign key_match = scan_slot.valid && (scan_slot.key == key_ff);

   // modulo datapath, one registered step per cycle
   assign recip_prod   = {{32{1'b0}}, key_ff} * {{hkvt_pkg::KEY_W{1'b0}}, RECIP_M};
   assign recip_shift  = recip_prod >> RECIP_SH;
   assign quot_times_b = quot_ff[AW:0] * BUCKETS_W;

   always_comb begin
      state_in     = state_ff;
      clr_addr_in  = clr_addr_ff;
      kind_in      = kind_ff;
      key_in       = key_ff;
      value_in     = value_ff;
      mod_cnt_in   = mod_cnt_ff;
      quot_in      = recip_shift[hkvt_pkg::KEY_W-1:0];
      rem_in       = key_ff[AW:0] - quot_times_b;
      bucket_in    = bucket_ff;
      way_in       = way_ff;
      found_in     = found_ff;
      has_free_in  = has_free_ff;
      hit_in       = hit_ff;
      free_in      = free_ff;
      res_found_in = res_found_ff;
      res_value_in = res_value_ff;
      res_full_in  = res_full_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_found_in = rsp_found_ff;
      rsp_value_in = rsp_value_ff;
      rsp_full_in  = rsp_full_ff;
      req_ready    = 1'b0;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = bucket_ff;
      ram_wr_data  = ram_rd_data;
      ram_rd_en    = 1'b0;
      new_slot     = hit_slot;

      // output register drains on a result transfer
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         hkvt_pkg::ST_CLEAR: begin
            // wipe valid marks, one bucket row per cycle
            ram_wr_en   = 1'b1;
            ram_wr_addr = clr_addr_ff;
            ram_wr_data = '0;
            clr_addr_in = clr_addr_ff + AW'(1);
            if (clr_addr_ff == AW'(BUCKETS - 1)) begin
               state_in = hkvt_pkg::ST_IDLE;
            end
         end
         hkvt_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               kind_in    = req_kind;
               key_in     = req_key;
               value_in   = req_value;
               mod_cnt_in = '0;
               if (POW2) begin
                  // power-of-two bucket count: the modulo is a mask
                  bucket_in = AW'(req_key & hkvt_pkg::KEY_W'(BUCKETS - 1));
                  state_in  = hkvt_pkg::ST_READ;
               end else begin
                  bucket_in = '0;
                  state_in  = hkvt_pkg::ST_MOD;
               end
            end
         end
         hkvt_pkg::ST_MOD: begin
            // quotient, then remainder, then the final compare and subtract
            mod_cnt_in = mod_cnt_ff + 2'd1;
            if (mod_cnt_ff == MOD_LAST) begin
               if (rem_ff >= BUCKETS_W) begin
                  bucket_in = AW'(rem_ff - BUCKETS_W);
               end else begin
                  bucket_in = rem_ff[AW-1:0];
               end
               state_in = hkvt_pkg::ST_READ;
            end
         end
         hkvt_pkg::ST_READ: begin
            // fetch the whole bucket row; it stays on rd_data through the scan
            ram_rd_en   = 1'b1;
            way_in      = '0;
            found_in    = 1'b0;
            has_free_in = 1'b0;
            hit_in      = '0;
            free_in     = '0;
            state_in    = hkvt_pkg::ST_SCAN;
         end
         hkvt_pkg::ST_SCAN: begin
            // first matching way wins, first empty way is the fill target
            if (scan_slot.valid) begin
               if (!found_ff && key_match) begin
                  found_in = 1'b1;
                  hit_in   = way_ff;
               end
            end else if (!has_free_ff) begin
               has_free_in = 1'b1;
               free_in     = way_ff;
            end
            way_in = way_ff + WW'(1);
            if (way_ff == WW'(WAYS - 1)) begin
               state_in = hkvt_pkg::ST_WRITE;
            end
         end
         hkvt_pkg::ST_WRITE: begin
            res_found_in = found_ff;
            res_value_in = hkvt_pkg::RES_MISS;
            res_full_in  = 1'b0;
            case (kind_ff)
               hkvt_pkg::KIND_PUT: begin
                  if (found_ff) begin
                     // overwrite value in place
                     new_slot.value = value_ff;
                     ram_wr_en      = 1'b1;
                     ram_wr_data[hit_ff * hkvt_pkg::SLOT_W +: hkvt_pkg::SLOT_W] = new_slot;
                  end else if (has_free_ff) begin
                     new_slot.valid = 1'b1;
                     new_slot.key   = key_ff;
                     new_slot.value = value_ff;
                     ram_wr_en      = 1'b1;
                     ram_wr_data[free_ff * hkvt_pkg::SLOT_W +: hkvt_pkg::SLOT_W] = new_slot;
                  end else begin
                     // bucket full, put dropped
                     res_full_in = 1'b1;
                  end
               end
               hkvt_pkg::KIND_GET: begin
                  if (found_ff) begin
                     res_value_in = {1'b0, hit_slot.value};
                  end
               end
               hkvt_pkg::KIND_REMOVE: begin
                  if (found_ff) begin
                     new_slot.valid = 1'b0;
                     ram_wr_en      = 1'b1;
                     ram_wr_data[hit_ff * hkvt_pkg::SLOT_W +: hkvt_pkg::SLOT_W] = new_slot;
                  end
               end
               default: begin
                  // unused kind: report only, no update
               end
            endcase
            state_in = hkvt_pkg::ST_RESP;
         end
         hkvt_pkg::ST_RESP: begin
            // hand over once the output register is free or draining
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in = 1'b1;
               rsp_found_in = res_found_ff;
               rsp_value_in = res_value_ff;
               rsp_full_in  = res_full_ff;
               state_in     = hkvt_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hkvt_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hkvt_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         rsp_valid_ff <= 1'b0;
         way_ff       <= '0;
         found_ff     <= 1'b0;
         has_free_ff  <= 1'b0;
         mod_cnt_ff   <= '0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         rsp_valid_ff <= rsp_valid_in;
         way_ff       <= way_in;
         found_ff     <= found_in;
         has_free_ff  <= has_free_in;
         mod_cnt_ff   <= mod_cnt_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      kind_ff      <= kind_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      bucket_ff    <= bucket_in;
      hit_ff       <= hit_in;
      free_ff      <= free_in;
      res_found_ff <= res_found_in;
      res_value_ff <= res_value_in;
      res_full_ff  <= res_full_in;
      rsp_found_ff <= rsp_found_in;
      rsp_value_ff <= rsp_value_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_found        = rsp_found_ff;
   assign rsp_result_value = rsp_value_ff;
   assign rsp_full_res     = rsp_full_ff;

endmodule

// File: rtl/hkvt_ram.sv
`timescale 1ns / 1ps

module hkvt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
